// ===== sv/sust_pkg.sv =====
// Shared types and constants for the sorted unique set table.
`timescale 1ns / 1ps
package sust_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEARCH = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_SPARE  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_FOUND   = 4'd0,
        STAT_EMPTY   = 4'd1,
        STAT_BELOW   = 4'd2,
        STAT_ABOVE   = 4'd3,
        STAT_ABSENT  = 4'd4,
        STAT_EXISTS  = 4'd5,
        STAT_NEW     = 4'd6,
        STAT_FULL    = 4'd7,
        STAT_CLEARED = 4'd8
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             clr;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic eq;
        logic bnd;
    } t_cell_flags;

endpackage

// ===== sv/sust_cell.sv =====
// One storage cell of the sorted key chain: holds a key, compares, shifts up.
`timescale 1ns / 1ps
module sust_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmp_en,
    input  logic [sust_pkg::KEY_W-1:0]  i_cmp_key,
    input  sust_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_prev_lt,
    input  logic [sust_pkg::KEY_W-1:0]  i_prev_key,
    input  logic                        i_prev_occ,
    output sust_pkg::t_cell_flags       o_flags,
    output logic [sust_pkg::KEY_W-1:0]  o_key,
    output logic                        o_occ
);
    import sust_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_occ;
    logic             r_lt;
    logic             r_eq;
    logic             w_bnd;

    assign w_bnd = !r_lt && i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            if (i_cmp_en) begin
                r_lt <= r_occ && (r_key < i_cmp_key);
                r_eq <= r_occ && (r_key == i_cmp_key);
            end
            if (i_ctl.clr) begin
                r_occ <= 1'b0;
            end else if (i_ctl.ins) begin
                if (w_bnd) begin
                    r_occ <= 1'b1;
                end else if (!r_lt) begin
                    r_occ <= i_prev_occ;
                end
            end
        end
    end

    // take the new key at the boundary, shift the upper part of the chain up
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (w_bnd) begin
                r_key <= i_ctl.key;
            end else if (!r_lt) begin
                r_key <= i_prev_key;
            end
        end
    end

    assign o_flags.lt  = r_lt;
    assign o_flags.eq  = r_eq;
    assign o_flags.bnd = w_bnd;
    assign o_key       = r_key;
    assign o_occ       = r_occ;

endmodule

// ===== sv/sorted_unique_set_table_unit.sv =====
// Top level of the sorted unique set table: request channel, cell chain, result register.
//
// Usage: a request word (i_req_type, i_key) enters on i_in_valid / o_in_ready and
// one result word (o_status, o_position, o_count_after) leaves on o_out_valid /
// i_out_ready for every request. Request codes: search, insert, clear; the spare
// code behaves as a search.
// The keys live in a chain of CAPACITY cells in ascending order. At the accept
// edge every cell compares its key with the request key; in the next cycle the
// compare flags give the rank of the key, the result is formed and, for an insert,
// every cell above the rank takes its lower neighbour's key in the same edge.
// The result is registered at the edge that ends the EXEC state, once the output
// register is free.
// A new request is taken only after the last one has left the compare-then-update pass
// through the cell chain; o_in_ready is high whenever no request is in that pass.
// A new request is taken while a finished result waits in the output register;
// when the receiver stalls, the update pass holds until the register frees, and
// further requests wait. Reset empties the table and the result register; keys
// held in the cells are not cleared and are never read above the count.
`timescale 1ns / 1ps
module sorted_unique_set_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sust_pkg::REQ_W-1:0]    i_req_type,
    input  logic [sust_pkg::KEY_W-1:0]    i_key,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sust_pkg::STAT_W-1:0]   o_status,
    output logic [sust_pkg::CNT_W-1:0]    o_position,
    output logic [sust_pkg::CNT_W-1:0]    o_count_after
);
    import sust_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [CNT_W-1:0]  r_position;
    logic [CNT_W-1:0]  n_position;

    logic              w_accept;
    logic              w_fire;
    logic              w_full;
    logic              w_any_eq;
    logic              w_any_bnd;
    logic [CNT_W-1:0]  w_bnd_idx;
    logic [CNT_W-1:0]  w_rank;
    t_cell_ctl         w_ctl;

    t_cell_flags       w_flags [CAPACITY];
    logic [KEY_W-1:0]  w_cell_key [CAPACITY];
    logic              w_cell_occ [CAPACITY];
    logic [CAPACITY-1:0] w_eq_vec;
    logic [CAPACITY-1:0] w_bnd_vec;

    assign w_accept = i_in_valid && o_in_ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic             w_prev_lt;
            logic [KEY_W-1:0] w_prev_key;
            logic             w_prev_occ;
            if (g == 0) begin : g_head
                assign w_prev_lt  = 1'b1;
                assign w_prev_key = r_key;
                assign w_prev_occ = 1'b1;
            end else begin : g_body
                assign w_prev_lt  = w_flags[g-1].lt;
                assign w_prev_key = w_cell_key[g-1];
                assign w_prev_occ = w_cell_occ[g-1];
            end
            sust_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmp_en   (w_accept),
                .i_cmp_key  (i_key),
                .i_ctl      (w_ctl),
                .i_prev_lt  (w_prev_lt),
                .i_prev_key (w_prev_key),
                .i_prev_occ (w_prev_occ),
                .o_flags    (w_flags[g]),
                .o_key      (w_cell_key[g]),
                .o_occ      (w_cell_occ[g])
            );
            assign w_eq_vec[g]  = w_flags[g].eq;
            assign w_bnd_vec[g] = w_flags[g].bnd;
        end
    endgenerate

    always_comb begin
        w_bnd_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_bnd_vec[i]) begin
                w_bnd_idx = w_bnd_idx | CNT_W'(i);
            end
        end
    end

    assign w_any_eq  = |w_eq_vec;
    assign w_any_bnd = |w_bnd_vec;
    assign w_rank    = w_any_bnd ? w_bnd_idx : CNT_W'(CAPACITY);
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_fire     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    w_fire  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_status   = STAT_FOUND;
        n_position = '0;
        n_count    = r_count;
        w_ctl.ins  = 1'b0;
        w_ctl.clr  = 1'b0;
        w_ctl.key  = r_key;
        case (r_req)
            REQ_CLEAR: begin
                n_status  = STAT_CLEARED;
                n_count   = '0;
                w_ctl.clr = w_fire;
            end
            REQ_INSERT: begin
                if (w_any_eq) begin
                    n_status   = STAT_EXISTS;
                    n_position = w_rank;
                end else if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_status   = STAT_NEW;
                    n_position = w_rank;
                    n_count    = r_count + 1'b1;
                    w_ctl.ins  = w_fire;
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else if (w_any_eq) begin
                    n_status   = STAT_FOUND;
                    n_position = w_rank;
                end else if (w_rank == '0) begin
                    n_status = STAT_BELOW;
                end else if (w_rank >= r_count) begin
                    n_status   = STAT_ABOVE;
                    n_position = r_count - 1'b1;
                end else begin
                    n_status   = STAT_ABSENT;
                    n_position = w_rank;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_key;
        end
        if (w_fire) begin
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_count_after = r_count;

endmodule
